// File: design/sqw_pkg.sv
// Shared types, codes and constants for the sleep queue wakeup block.
package sqw_pkg;

    // Fixed field widths on the stream ports
    localparam int ACT_W   = 3;
    localparam int TID_W   = 8;
    localparam int TICKS_W = 16;

    // Most threads a single tick may wake, and the width of that count
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Action codes carried in the input tuser
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TAKE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAKE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;   // input word accepted this cycle
        logic pop;     // wake the head and load it as a result
        logic settle;  // end of tick wakeups: re-place head, maybe load empty result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_tick;  // input word carries a tick
        logic wake_ok;  // head is due and the wake budget is not spent
        logic n_zero;   // no thread woken yet in this tick
        logic more;     // held result came from a tick wakeup
    } stat_t;

endpackage

// File: design/sqw_ctrl.sv
// Controller state machine: sequences accept, tick wakeups and result delivery.
module sqw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  sqw_pkg::stat_t stat,
    output sqw_pkg::cmd_t  cmd
);
    import sqw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.in_tick ? ST_WAKE : ST_EMIT;
                end
            end
            ST_WAKE: begin
                if (stat.wake_ok || stat.n_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    state_next = stat.more ? ST_WAKE : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_WAKE: begin
                cmd.pop    = stat.wake_ok;
                cmd.settle = !stat.wake_ok;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/sqw_datapath.sv
// Datapath: row of list cells with compare-and-shift update, and the result register.
module sqw_datapath #(
    parameter int CAPACITY  = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sqw_pkg::ACT_W-1:0]  s_action,
    input  logic [sqw_pkg::TID_W-1:0]  s_thread_id,
    input  logic [sqw_pkg::TICKS_W-1:0] s_sleep_ticks,
    input  sqw_pkg::cmd_t              cmd,
    output sqw_pkg::stat_t             stat,
    output logic [sqw_pkg::TID_W-1:0]  out_thread,
    output logic                       found,
    output logic                       now_empty,
    output logic                       dropped,
    output logic                       last
);
    import sqw_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // List cells: thread id and remaining ticks, head at index 0
    logic [ID_BITS-1:0]   thr_reg  [CAPACITY];
    logic [ID_BITS-1:0]   thr_next [CAPACITY];
    logic [TIME_BITS-1:0] rem_reg  [CAPACITY];
    logic [TIME_BITS-1:0] rem_next [CAPACITY];
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;

    // Tick bookkeeping
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     n_next;
    logic                 empty_reg;
    logic                 empty_next;
    logic                 more_reg;
    logic                 more_next;

    // Result register
    logic [TID_W-1:0]     res_thr_reg;
    logic                 res_found_reg;
    logic                 res_empty_reg;
    logic                 res_drop_reg;
    logic                 res_last_reg;
    logic [TID_W-1:0]     res_thr_next;
    logic                 res_found_next;
    logic                 res_empty_next;
    logic                 res_drop_next;
    logic                 res_last_next;
    logic                 res_load;

    // Neighbor views of the cells
    logic [ID_BITS-1:0]   thr_up [CAPACITY];
    logic [ID_BITS-1:0]   thr_dn [CAPACITY];
    logic [TIME_BITS-1:0] rem_up [CAPACITY];
    logic [TIME_BITS-1:0] rem_dn [CAPACITY];

    logic [ID_BITS-1:0]   id_in;
    logic [TIME_BITS-1:0] t_in;
    logic [CAPACITY-1:0]  valid;
    logic [CAPACITY-1:0]  gt;
    logic [CAPACITY:0]    pre;
    logic [CAPACITY-1:0]  match;
    logic [CAPACITY:0]    nm;
    logic [CAPACITY-1:0]  lt;
    logic [CAPACITY:0]    run;
    logic [CAPACITY-1:0]  due1;
    logic                 full;
    logic                 hit;
    logic                 nonempty;
    logic                 all_due;
    logic                 head_due;
    logic                 next_due;
    logic                 replace_en;
    logic                 is_append;

    assign id_in = ID_BITS'(s_thread_id);
    assign t_in  = TIME_BITS'(s_sleep_ticks);

    // Wire up neighbor views; end cells see themselves
    for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
        if (g < CAPACITY - 1) begin : g_up
            assign thr_up[g] = thr_reg[g+1];
            assign rem_up[g] = rem_reg[g+1];
        end else begin : g_up_end
            assign thr_up[g] = thr_reg[g];
            assign rem_up[g] = rem_reg[g];
        end
        if (g > 0) begin : g_dn
            assign thr_dn[g] = thr_reg[g-1];
            assign rem_dn[g] = rem_reg[g-1];
        end else begin : g_dn_end
            assign thr_dn[g] = thr_reg[g];
            assign rem_dn[g] = rem_reg[g];
        end
    end

    // Per-cell compares and prefix chains
    always_comb begin
        pre[0] = 1'b1;
        nm[0]  = 1'b1;
        run[0] = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i]  = OCC_W'(i) < occ_reg;
            gt[i]     = valid[i] && (is_append || (t_in > rem_reg[i]));
            pre[i+1]  = pre[i] & gt[i];
            match[i]  = valid[i] && (thr_reg[i] == id_in);
            nm[i+1]   = nm[i] & ~match[i];
            due1[i]   = !valid[i] || (rem_reg[i] <= TIME_BITS'(1));
            lt[i]     = (i > 0) && valid[i] && (rem_reg[0] > rem_reg[i]);
            if (i > 0) begin
                run[i] = run[i-1] & lt[i];
            end
        end
        run[CAPACITY] = 1'b0;
    end

    assign is_append  = (s_action == ACT_APPEND);
    assign full       = (occ_reg == OCC_W'(CAPACITY));
    assign nonempty   = (occ_reg != '0);
    assign hit        = ~nm[CAPACITY];
    assign all_due    = (&due1) && (32'(occ_reg) <= 32'(MAX_RESULTS));
    assign head_due   = nonempty && (rem_reg[0] == '0);
    assign next_due   = (occ_reg > OCC_W'(1)) && (rem_reg[1] == '0);
    assign replace_en = nonempty && (rem_reg[0] != '0) && (n_reg < CNT_W'(MAX_RESULTS));

    // Status to the controller
    assign stat.in_tick = (s_action == ACT_TICK);
    assign stat.wake_ok = head_due && (n_reg < CNT_W'(MAX_RESULTS));
    assign stat.n_zero  = (n_reg == '0);
    assign stat.more    = more_reg;

    // Cell update
    always_comb begin
        thr_next = thr_reg;
        rem_next = rem_reg;
        occ_next = occ_reg;
        if (cmd.start) begin
            case (s_action)
                ACT_APPEND, ACT_INSERT: begin
                    if (!full) begin
                        // Open a slot at the sorted spot, shift the tail up
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!pre[i+1]) begin
                                if (pre[i]) begin
                                    thr_next[i] = id_in;
                                    rem_next[i] = t_in;
                                end else begin
                                    thr_next[i] = thr_dn[i];
                                    rem_next[i] = rem_dn[i];
                                end
                            end
                        end
                        occ_next = occ_reg + OCC_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    // Close the gap at the first match
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!nm[i+1]) begin
                            thr_next[i] = thr_up[i];
                            rem_next[i] = rem_up[i];
                        end
                    end
                    if (hit) begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
                ACT_TAKE: begin
                    if (nonempty) begin
                        thr_next = thr_up;
                        rem_next = rem_up;
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
                ACT_TICK: begin
                    // Count down every cell, saturating at zero
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (rem_reg[i] != '0) begin
                            rem_next[i] = rem_reg[i] - TIME_BITS'(1);
                        end
                    end
                end
                default: begin
                    occ_next = occ_reg;
                end
            endcase
        end else if (cmd.pop) begin
            // Drop the woken head
            thr_next = thr_up;
            rem_next = rem_up;
            occ_next = occ_reg - OCC_W'(1);
        end else if (cmd.settle && replace_en) begin
            // Move the head back among the entries behind it
            for (int i = 0; i < CAPACITY; i++) begin
                if (run[i+1]) begin
                    thr_next[i] = thr_up[i];
                    rem_next[i] = rem_up[i];
                end else if (run[i]) begin
                    thr_next[i] = thr_reg[0];
                    rem_next[i] = rem_reg[0];
                end
            end
        end
    end

    // Tick bookkeeping update
    always_comb begin
        n_next     = n_reg;
        empty_next = empty_reg;
        more_next  = more_reg;
        if (cmd.start) begin
            n_next     = '0;
            empty_next = all_due;
            more_next  = 1'b0;
        end else if (cmd.pop) begin
            n_next    = n_reg + CNT_W'(1);
            more_next = 1'b1;
        end else if (cmd.settle) begin
            more_next = 1'b0;
        end
    end

    // Result word
    always_comb begin
        res_thr_next   = '0;
        res_found_next = 1'b0;
        res_empty_next = (occ_next == '0);
        res_drop_next  = 1'b0;
        res_last_next  = 1'b1;
        res_load       = 1'b0;
        if (cmd.start) begin
            res_load = !stat.in_tick;
            case (s_action)
                ACT_APPEND, ACT_INSERT: begin
                    res_drop_next = full;
                end
                ACT_REMOVE: begin
                    res_found_next = hit;
                end
                ACT_TAKE: begin
                    res_found_next = nonempty;
                    res_thr_next   = nonempty ? TID_W'(thr_reg[0]) : '0;
                end
                default: begin
                    res_found_next = 1'b0;
                end
            endcase
        end else if (cmd.pop) begin
            res_load       = 1'b1;
            res_thr_next   = TID_W'(thr_reg[0]);
            res_found_next = 1'b1;
            res_empty_next = empty_reg;
            res_last_next  = !(next_due && (n_reg < CNT_W'(MAX_RESULTS - 1)));
        end else if (cmd.settle) begin
            res_load       = (n_reg == '0);
            res_empty_next = empty_reg;
        end
    end

    // Hold cells and result payload
    always_ff @(posedge aclk) begin
        thr_reg <= thr_next;
        rem_reg <= rem_next;
        if (res_load) begin
            res_thr_reg   <= res_thr_next;
            res_found_reg <= res_found_next;
            res_empty_reg <= res_empty_next;
            res_drop_reg  <= res_drop_next;
            res_last_reg  <= res_last_next;
        end
    end

    // Hold occupancy and tick bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            n_reg     <= '0;
            empty_reg <= 1'b0;
            more_reg  <= 1'b0;
        end else begin
            occ_reg   <= occ_next;
            n_reg     <= n_next;
            empty_reg <= empty_next;
            more_reg  <= more_next;
        end
    end

    assign out_thread = res_thr_reg;
    assign found      = res_found_reg;
    assign now_empty  = res_empty_reg;
    assign dropped    = res_drop_reg;
    assign last       = res_last_reg;

endmodule

// File: design/sleep_queue_wakeup.sv
// Top level of the sleep queue wakeup block: stream ports, controller and datapath.
//
// Keeps up to CAPACITY sleeping threads in an ordered list of cells. Each input
// word carries an action in s_tuser (append at tail, sorted insert, remove by id,
// take head, tick) and returns one or more result words; the final one of a step
// has m_tlast set. One item is in flight at a time. Append, insert, remove, take
// and unused actions are accepted, then their result is held until taken. A tick
// that wakes nobody offers one empty result; one that wakes n threads (n at most
// 16) pops one due head per wake/emit pair. In both cases the controller also
// re-places a head that is not yet due. Each result can be stalled by m_tready.
// Inserts and removes update all cells at once through parallel compares.
module sleep_queue_wakeup #(
    parameter int CAPACITY  = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // thread_id[7:0], sleep_ticks[23:8]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_thread[7:0]
    output logic [2:0]  m_tuser,   // found[0], now_empty[1], dropped[2]
    output logic        m_tlast
);
    import sqw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sqw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sqw_datapath #(
        .CAPACITY  (CAPACITY),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_tuser[ACT_W-1:0]),
        .s_thread_id   (s_tdata[TID_W-1:0]),
        .s_sleep_ticks (s_tdata[TID_W+TICKS_W-1:TID_W]),
        .cmd           (cmd),
        .stat          (stat),
        .out_thread    (m_tdata),
        .found         (m_tuser[0]),
        .now_empty     (m_tuser[1]),
        .dropped       (m_tuser[2]),
        .last          (m_tlast)
    );

`ifndef SYNTHESIS
    // One step at a time: never accept while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input accepted while a result is pending");

    // A step that is not finished keeps the input closed
    a_step_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
        else $error("input reopened before the final result of a step");

    // A refused insert never reports a found thread
    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
        else $error("result flags found and dropped together");
`endif

endmodule
